/* design/odd_pkg.sv */
// shared types, constants and helpers for the oriented detection decoder
// no dependencies; used by odd_front, odd_queue, odd_back and the top level
package odd_pkg;

    localparam int DataW     = 32;
    localparam int OffW      = 12;
    localparam int ScaleW    = 24;
    localparam int ThrW      = 17;
    localparam int NcW       = 8;
    localparam int ClassW    = 8;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 24;
    localparam int DiffW     = DataW + 1;
    localparam int ProdW     = 58;
    localparam int FracW     = 16;

    localparam int MaxClassesDef = 255;
    localparam int QueueDepth    = 2;

    localparam logic [OffW-1:0]   OffsetReset    = 12'd0;
    localparam logic [ScaleW-1:0] InvScaleReset  = 24'd65536;
    localparam logic [ThrW-1:0]   ThresholdReset = 17'd19661;
    localparam logic [NcW-1:0]    NumClassReset  = 8'd2;

    // 180/pi in Q16.16, rounded to nearest
    localparam logic signed [23:0] DegPerRad = 24'sd3754936;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_OFFSET_X  = 3'd0,
        CFG_OFFSET_Y  = 3'd1,
        CFG_INV_SCALE = 3'd2,
        CFG_THRESHOLD = 3'd3,
        CFG_NUM_CLASS = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [OffW-1:0]   offset_x;
        logic [OffW-1:0]   offset_y;
        logic [ScaleW-1:0] inv_scale;
        logic [ThrW-1:0]   threshold;
        logic [NcW-1:0]    class_count;
    } t_cfg;

    // one decoded detection waiting for scaling
    typedef struct packed {
        logic signed [DiffW-1:0] dx;
        logic signed [DiffW-1:0] dy;
        logic signed [DataW-1:0] w;
        logic signed [DataW-1:0] h;
        logic signed [DataW-1:0] angle;
        logic signed [DataW-1:0] conf;
        logic [ClassW-1:0]       cls;
    } t_job;

    // floor shift by the fraction width, then clamp to the signed 32 bit range
    function automatic logic signed [DataW-1:0] sat_shift(input logic signed [ProdW-1:0] p);
        logic signed [ProdW-FracW-1:0] s;
        logic signed [ProdW-FracW-1:0] hi;
        logic signed [ProdW-FracW-1:0] lo;
        logic signed [DataW-1:0]       r;
        s  = p[ProdW-1:FracW];
        hi = (ProdW-FracW)'(2147483647);
        lo = -hi - (ProdW-FracW)'(1);
        if (s > hi) begin
            r = 32'sh7fffffff;
        end else if (s < lo) begin
            r = 32'sh80000000;
        end else begin
            r = s[DataW-1:0];
        end
        return r;
    endfunction

endpackage

/* design/odd_front.sv */
// front end: tracks the slot within each detection, captures the box and the best class
// depends on odd_pkg; pushes finished detections into odd_queue
module odd_front #(
    parameter int MAX_CLASSES = odd_pkg::MaxClassesDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [odd_pkg::DataW-1:0] i_value,
    input  odd_pkg::t_cfg                 i_cfg,
    input  logic                          i_full,
    output logic                          o_push,
    output odd_pkg::t_job                 o_job
);

    localparam int EffMax = (MAX_CLASSES < 255) ? MAX_CLASSES : 255;
    localparam int PosW   = $clog2(EffMax + 5);
    localparam logic [odd_pkg::NcW-1:0] NcMax = odd_pkg::NcW'(EffMax);

    logic [PosW-1:0]                    r_pos;
    logic [PosW-1:0]                    n_pos;
    logic signed [odd_pkg::DataW-1:0]   r_box [4];
    logic signed [odd_pkg::DataW-1:0]   r_best;
    logic [odd_pkg::ClassW-1:0]         r_cls;

    logic [odd_pkg::NcW-1:0] nc_eff;
    logic [PosW-1:0]         angle_slot;
    logic [PosW-1:0]         rel_pos;
    logic                    accept;
    logic                    is_angle;
    logic                    pass;

    always_comb begin
        if (i_cfg.class_count == '0) begin
            nc_eff = odd_pkg::NcW'(1);
        end else if (i_cfg.class_count > NcMax) begin
            nc_eff = NcMax;
        end else begin
            nc_eff = i_cfg.class_count;
        end
    end

    assign angle_slot = PosW'({1'b0, nc_eff} + 9'd4);
    assign rel_pos    = r_pos - PosW'(4);
    assign o_stall    = i_full;
    assign accept     = i_valid && !o_stall;
    assign is_angle   = (r_pos >= angle_slot);
    assign pass       = ($signed({r_best[odd_pkg::DataW-1], r_best})
                         >= $signed({16'b0, i_cfg.threshold}));
    assign o_push     = accept && is_angle && pass;

    always_comb begin
        o_job.dx    = $signed({r_box[0][odd_pkg::DataW-1], r_box[0]})
                      - $signed({5'b0, i_cfg.offset_x, 16'b0});
        o_job.dy    = $signed({r_box[1][odd_pkg::DataW-1], r_box[1]})
                      - $signed({5'b0, i_cfg.offset_y, 16'b0});
        o_job.w     = r_box[2];
        o_job.h     = r_box[3];
        o_job.angle = i_value;
        o_job.conf  = r_best;
        o_job.cls   = r_cls;
    end

    always_comb begin
        if (is_angle) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + PosW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    // payload captures, written before they are read in every detection
    always_ff @(posedge i_clk) begin
        if (accept && !is_angle) begin
            if (r_pos < PosW'(4)) begin
                r_box[r_pos[1:0]] <= i_value;
            end else if (r_pos == PosW'(4)) begin
                r_best <= i_value;
                r_cls  <= '0;
            end else if (i_value > r_best) begin
                r_best <= i_value;
                r_cls  <= odd_pkg::ClassW'(rel_pos);
            end
        end
    end

    a_push_only_on_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> is_angle && !i_full)
        else $error("detection pushed outside the angle slot or into a full queue");

    a_pos_wraps_after_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_angle |=> r_pos == '0)
        else $error("slot counter did not return to zero after the angle");

endmodule

/* design/odd_queue.sv */
// short queue of decoded detections between the front end and the scaling back end
// depends on odd_pkg for the entry type
module odd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  odd_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output odd_pkg::t_job o_job
);

    localparam int PtrW = (odd_pkg::QueueDepth > 1) ? $clog2(odd_pkg::QueueDepth) : 1;
    localparam int CntW = $clog2(odd_pkg::QueueDepth + 1);

    odd_pkg::t_job   r_mem [odd_pkg::QueueDepth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CntW'(odd_pkg::QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(odd_pkg::QueueDepth - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(odd_pkg::QueueDepth - 1)) ? '0 : r_rd + PtrW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CntW'(1);
                2'b01:   r_cnt <= r_cnt - CntW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(odd_pkg::QueueDepth))
        else $error("queue count beyond depth");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

endmodule

/* design/odd_back.sv */
// back end: scales the box and angle, then saturates into the output register
// depends on odd_pkg; pops detections from odd_queue
module odd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  odd_pkg::t_job                      i_job,
    output logic                               o_pop,
    input  logic [odd_pkg::ScaleW-1:0]         i_inv_scale,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [odd_pkg::DataW-1:0]   o_center_x,
    output logic signed [odd_pkg::DataW-1:0]   o_center_y,
    output logic signed [odd_pkg::DataW-1:0]   o_box_width,
    output logic signed [odd_pkg::DataW-1:0]   o_box_height,
    output logic signed [odd_pkg::DataW-1:0]   o_angle_degrees,
    output logic signed [odd_pkg::DataW-1:0]   o_confidence,
    output logic [odd_pkg::ClassW-1:0]         o_class_index
);

    logic                                r_a_valid;
    logic signed [odd_pkg::ProdW-1:0]    r_px;
    logic signed [odd_pkg::ProdW-1:0]    r_py;
    logic signed [odd_pkg::ProdW-1:0]    r_pw;
    logic signed [odd_pkg::ProdW-1:0]    r_ph;
    logic signed [odd_pkg::ProdW-1:0]    r_pa;
    logic signed [odd_pkg::DataW-1:0]    r_a_conf;
    logic [odd_pkg::ClassW-1:0]          r_a_cls;
    logic                                r_o_valid;

    logic signed [odd_pkg::ScaleW:0]     k;
    logic signed [odd_pkg::ProdW-1:0]    n_px;
    logic signed [odd_pkg::ProdW-1:0]    n_py;
    logic signed [odd_pkg::ProdW-1:0]    n_pw;
    logic signed [odd_pkg::ProdW-1:0]    n_ph;
    logic signed [odd_pkg::ProdW-1:0]    n_pa;
    logic                                adv_a;

    assign k     = $signed({1'b0, i_inv_scale});
    assign n_px  = i_job.dx * k;
    assign n_py  = i_job.dy * k;
    assign n_pw  = i_job.w * k;
    assign n_ph  = i_job.h * k;
    assign n_pa  = i_job.angle * odd_pkg::DegPerRad;

    assign adv_a = r_a_valid && (!r_o_valid || !i_stall);
    assign o_pop = i_q_valid && (!r_a_valid || adv_a);

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_pop) begin
            r_a_valid <= 1'b1;
        end else if (adv_a) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_px     <= n_px;
            r_py     <= n_py;
            r_pw     <= n_pw;
            r_ph     <= n_ph;
            r_pa     <= n_pa;
            r_a_conf <= i_job.conf;
            r_a_cls  <= i_job.cls;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv_a) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            o_center_x      <= odd_pkg::sat_shift(r_px);
            o_center_y      <= odd_pkg::sat_shift(r_py);
            o_box_width     <= odd_pkg::sat_shift(r_pw);
            o_box_height    <= odd_pkg::sat_shift(r_ph);
            o_angle_degrees <= odd_pkg::sat_shift(r_pa);
            o_confidence    <= r_a_conf;
            o_class_index   <= r_a_cls;
        end
    end

    assign o_valid = r_o_valid;

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_o_valid && i_stall |=> r_a_valid && $stable(r_px))
        else $error("product stage dropped while output stalled");

    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_valid && (!r_a_valid || adv_a))
        else $error("pop without room in product stage");

endmodule

/* design/oriented_detection_decode.sv */
// top level of the oriented detection decoder: configuration registers and the three parts
// depends on odd_pkg, odd_front, odd_queue and odd_back
//
// Takes one signed Q16.16 value per cycle (x, y, w, h, one score per class, angle) and
// emits at most one scaled detection per angle value, when the best score reaches the
// threshold. Input accepts one value every cycle as long as the two-entry detection
// queue has room; a detection then passes through the back end (multiply stage, then
// shift/saturate into the output register). A detection is at least six values
// long, so the back end keeps up unless the output side stalls. Registers may only be
// written while the block holds no pending detection.
module oriented_detection_decode #(
    parameter int MAX_CLASSES = odd_pkg::MaxClassesDef
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [odd_pkg::DataW-1:0]     i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [odd_pkg::DataW-1:0]     o_center_x,
    output logic signed [odd_pkg::DataW-1:0]     o_center_y,
    output logic signed [odd_pkg::DataW-1:0]     o_box_width,
    output logic signed [odd_pkg::DataW-1:0]     o_box_height,
    output logic signed [odd_pkg::DataW-1:0]     o_angle_degrees,
    output logic signed [odd_pkg::DataW-1:0]     o_confidence,
    output logic [odd_pkg::ClassW-1:0]           o_class_index,
    input  logic                                 i_cfg_we,
    input  logic [odd_pkg::CfgIdxW-1:0]          i_cfg_index,
    input  logic [odd_pkg::CfgDataW-1:0]         i_cfg_data
);

    odd_pkg::t_cfg r_cfg;
    odd_pkg::t_job push_job;
    odd_pkg::t_job head_job;
    logic          push;
    logic          full;
    logic          q_valid;
    logic          pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x    <= odd_pkg::OffsetReset;
            r_cfg.offset_y    <= odd_pkg::OffsetReset;
            r_cfg.inv_scale   <= odd_pkg::InvScaleReset;
            r_cfg.threshold   <= odd_pkg::ThresholdReset;
            r_cfg.class_count <= odd_pkg::NumClassReset;
        end else if (i_cfg_we) begin
            case (odd_pkg::t_cfg_idx'(i_cfg_index))
                odd_pkg::CFG_OFFSET_X:  r_cfg.offset_x    <= i_cfg_data[odd_pkg::OffW-1:0];
                odd_pkg::CFG_OFFSET_Y:  r_cfg.offset_y    <= i_cfg_data[odd_pkg::OffW-1:0];
                odd_pkg::CFG_INV_SCALE: r_cfg.inv_scale   <= i_cfg_data[odd_pkg::ScaleW-1:0];
                odd_pkg::CFG_THRESHOLD: r_cfg.threshold   <= i_cfg_data[odd_pkg::ThrW-1:0];
                odd_pkg::CFG_NUM_CLASS: r_cfg.class_count <= i_cfg_data[odd_pkg::NcW-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    odd_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    odd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    odd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_job           (head_job),
        .o_pop           (pop),
        .i_inv_scale     (r_cfg.inv_scale),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_center_x      (o_center_x),
        .o_center_y      (o_center_y),
        .o_box_width     (o_box_width),
        .o_box_height    (o_box_height),
        .o_angle_degrees (o_angle_degrees),
        .o_confidence    (o_confidence),
        .o_class_index   (o_class_index)
    );

endmodule

/* bench/tb_oriented_detection_decode.sv */
// testbench for oriented_detection_decode: directed table, then random register phases
// depends on odd_pkg and the decoder RTL; self-checking against an in-bench predictor
module tb_oriented_detection_decode;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RandomWords    = 1600;
    localparam int     SettleCycles   = 8;
    localparam int     LongHoldCycles = 400;
    localparam longint DegPerRadQ16   = 3754936;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] box_width;
        logic signed [31:0] box_height;
        logic signed [31:0] angle_degrees;
        logic signed [31:0] confidence;
        logic [7:0]         class_index;
    } t_det;

    typedef struct {
        bit                 is_write;
        odd_pkg::t_cfg_idx  reg_idx;
        logic [23:0]        reg_val;
        logic signed [31:0] word;
        bit                 typed;
        t_det               want;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic signed [31:0]  i_value = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic signed [31:0]  o_center_x;
    logic signed [31:0]  o_center_y;
    logic signed [31:0]  o_box_width;
    logic signed [31:0]  o_box_height;
    logic signed [31:0]  o_angle_degrees;
    logic signed [31:0]  o_confidence;
    logic [7:0]          o_class_index;
    logic                i_cfg_we = 1'b0;
    logic [2:0]          i_cfg_index = '0;
    logic [23:0]         i_cfg_data = '0;

    oriented_detection_decode u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_center_x      (o_center_x),
        .o_center_y      (o_center_y),
        .o_box_width     (o_box_width),
        .o_box_height    (o_box_height),
        .o_angle_degrees (o_angle_degrees),
        .o_confidence    (o_confidence),
        .o_class_index   (o_class_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // register shadows, reset values
    logic [11:0] cfg_off_x = 12'd0;
    logic [11:0] cfg_off_y = 12'd0;
    logic [23:0] cfg_inv   = 24'd65536;
    logic [16:0] cfg_thr   = 17'd19661;
    logic [7:0]  cfg_nc    = 8'd2;

    // decoder state
    logic [8:0]         pos_q = '0;
    logic signed [31:0] box_q [4] = '{default: '0};
    logic signed [31:0] best_q = '0;
    logic [7:0]         best_cls_q = '0;

    t_det      pending_dets [$];
    t_plan_row directed_plan [$];

    int fail_count   = 0;
    int words_sent   = 0;
    int dets_checked = 0;
    int reg_writes   = 0;
    int phases_run   = 0;
    int tx_quiet     = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int rx_stall_left = 0;
    int rx_quiet_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] extreme_word();
        case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh00000000;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic int eff_classes();
        int n;
        n = cfg_nc;
        if (n < 1) n = 1;
        if (n > odd_pkg::MaxClassesDef) n = odd_pkg::MaxClassesDef;
        return n;
    endfunction

    // exact product, floor shift, clamp to 32 bits
    function automatic logic signed [31:0] scale_sat(input longint v, input longint k);
        longint p;
        p = (v * k) >>> 16;
        if (p > 64'sh7fffffff) return 32'sh7fffffff;
        if (p < -64'sh80000000) return 32'sh80000000;
        return p[31:0];
    endfunction

    function automatic bit decode_word(input logic signed [31:0] v, output t_det d);
        int     slot;
        longint k;
        d = '0;
        slot = 4 + eff_classes();
        k = longint'(cfg_inv);
        // also covers a count lowered mid detection
        if (pos_q >= slot) begin
            pos_q = '0;
            if (longint'(best_q) < longint'(cfg_thr)) return 1'b0;
            d.center_x      = scale_sat(longint'(box_q[0]) - (longint'(cfg_off_x) <<< 16), k);
            d.center_y      = scale_sat(longint'(box_q[1]) - (longint'(cfg_off_y) <<< 16), k);
            d.box_width     = scale_sat(longint'(box_q[2]), k);
            d.box_height    = scale_sat(longint'(box_q[3]), k);
            d.angle_degrees = scale_sat(longint'(v), DegPerRadQ16);
            d.confidence    = best_q;
            d.class_index   = best_cls_q;
            return 1'b1;
        end
        if (pos_q < 4) begin
            box_q[pos_q[1:0]] = v;
        end else if (pos_q == 4) begin
            best_q = v;
            best_cls_q = '0;
        end else if (v > best_q) begin
            // strictly greater, so the first of equal scores stays
            best_q = v;
            best_cls_q = 8'(pos_q - 9'd4);
        end
        pos_q = pos_q + 9'd1;
        return 1'b0;
    endfunction

    function automatic void add_word(input logic signed [31:0] v);
        t_plan_row row;
        row.is_write = 1'b0;
        row.reg_idx  = odd_pkg::CFG_OFFSET_X;
        row.reg_val  = '0;
        row.word     = v;
        row.typed    = 1'b0;
        row.want     = '0;
        directed_plan.insert(directed_plan.size(), row);
    endfunction

    function automatic void add_checked(input logic signed [31:0] v, input t_det want);
        add_word(v);
        directed_plan[$].typed = 1'b1;
        directed_plan[$].want  = want;
    endfunction

    function automatic void add_write(input odd_pkg::t_cfg_idx idx, input logic [23:0] val);
        t_plan_row row;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        row.word     = '0;
        row.typed    = 1'b0;
        row.want     = '0;
        directed_plan.insert(directed_plan.size(), row);
    endfunction

    // wait until every expected detection is out and the back end has settled
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_dets.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input odd_pkg::t_cfg_idx idx, input logic [23:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            odd_pkg::CFG_OFFSET_X:  cfg_off_x = val[11:0];
            odd_pkg::CFG_OFFSET_Y:  cfg_off_y = val[11:0];
            odd_pkg::CFG_INV_SCALE: cfg_inv   = val[23:0];
            odd_pkg::CFG_THRESHOLD: cfg_thr   = val[16:0];
            odd_pkg::CFG_NUM_CLASS: cfg_nc    = val[7:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic signed [31:0] v, input bit typed, input t_det want);
        int   gap;
        t_det pred;
        bit   hit;
        if (tx_quiet != 0) begin
            tx_quiet--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0) tx_quiet = $urandom_range(30, 150);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        hit = decode_word(v, pred);
        if (typed) begin
            pending_dets.insert(pending_dets.size(), want);
        end else if (hit) begin
            pending_dets.insert(pending_dets.size(), pred);
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // output side: random stalls, quiet stretches, and one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            rx_stall_left <= LongHoldCycles;
            i_stall       <= 1'b1;
        end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_stall       <= 1'b1;
        end else if (rx_quiet_left != 0) begin
            rx_quiet_left <= rx_quiet_left - 1;
            i_stall       <= 1'b0;
        end else begin
            i_stall       <= 1'b0;
            rx_stall_left <= pick_gap();
            rx_quiet_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                          : $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_det want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dets.size() == 0) begin
                $display("%0t ns: unexpected detection, class %0d confidence %0d",
                         $time, o_class_index, o_confidence);
                fail_count++;
            end else begin
                want = pending_dets.pop_front();
                check_field("center_x", want.center_x, o_center_x);
                check_field("center_y", want.center_y, o_center_y);
                check_field("box_width", want.box_width, o_box_width);
                check_field("box_height", want.box_height, o_box_height);
                check_field("angle_degrees", want.angle_degrees, o_angle_degrees);
                check_field("confidence", want.confidence, o_confidence);
                check_field("class_index", want.class_index, o_class_index);
                dets_checked++;
            end
        end
    end

    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int                 base;
        int                 slot;
        int                 r;
        int                 phase_len;
        logic signed [31:0] w;
        logic [11:0]        ox;
        logic [11:0]        oy;
        logic [23:0]        inv;
        logic [16:0]        thr;
        logic [7:0]         nc;

        // reset values: plain pass-through of a box, one radian of angle
        add_word(32'sd655360);
        add_word(32'sd1310720);
        add_word(32'sd262144);
        add_word(32'sd131072);
        add_word(32'sd32768);
        add_word(32'sd16384);
        add_checked(32'sd65536, '{655360, 1310720, 262144, 131072, 3754936, 32768, 8'd0});
        // box extremes pass through, angle saturates, later class wins on a larger score
        add_word(32'sh7fffffff);
        add_word(32'sh80000000);
        add_word(32'sh80000000);
        add_word(32'sh7fffffff);
        add_word(32'sd16384);
        add_word(32'sh7fffffff);
        add_checked(32'sh80000000, '{32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                                     32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 8'd1});
        // class count zero acts as one, zero scale, threshold above one
        add_write(odd_pkg::CFG_NUM_CLASS, 24'd0);
        add_write(odd_pkg::CFG_THRESHOLD, 24'd131071);
        add_write(odd_pkg::CFG_INV_SCALE, 24'd0);
        add_word(32'sd123456);
        add_word(-32'sd7);
        add_word(32'sh7fffffff);
        add_word(32'sh80000000);
        add_word(32'sh7fffffff);
        add_checked(32'sd0, '{0, 0, 0, 0, 0, 32'sh7fffffff, 8'd0});
        // max offsets and scale, tied scores, count lowered mid detection
        add_write(odd_pkg::CFG_THRESHOLD, 24'd0);
        add_write(odd_pkg::CFG_OFFSET_X, 24'd4095);
        add_write(odd_pkg::CFG_OFFSET_Y, 24'd4095);
        add_write(odd_pkg::CFG_INV_SCALE, 24'hffffff);
        add_write(odd_pkg::CFG_NUM_CLASS, 24'd3);
        add_word(32'sd0);
        add_word(32'sh0fff0000);
        add_word(32'sd1);
        add_word(-32'sd1);
        add_word(32'sd5);
        add_word(32'sd5);
        add_write(odd_pkg::CFG_NUM_CLASS, 24'd1);
        add_word(-32'sd1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_write) begin
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            end else begin
                send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // random phases; a phase may end mid detection, so new settings hit partial ones
        base = words_sent;
        while (words_sent - base < RandomWords) begin
            r  = $urandom_range(0, 9);
            ox = (r == 0) ? 12'd0 : (r == 1) ? 12'hfff : 12'($urandom);
            r  = $urandom_range(0, 9);
            oy = (r == 0) ? 12'd0 : (r == 1) ? 12'hfff : 12'($urandom);
            case ($urandom_range(0, 19))
                0:       inv = 24'd0;
                1:       inv = 24'hffffff;
                2:       inv = 24'd1;
                3, 4, 5: inv = 24'd65536;
                6, 7:    inv = 24'($urandom);
                default: inv = 24'($urandom_range(16384, 262144));
            endcase
            case ($urandom_range(0, 9))
                0:       thr = 17'd0;
                1:       thr = 17'd65536;
                2:       thr = 17'd131071;
                3:       thr = 17'($urandom);
                default: thr = 17'($urandom_range(0, 40000));
            endcase
            if (phases_run == 1) begin
                // each non-negative best emits, so the queue is sure to fill in the hold
                thr = 17'd0;
                nc = 8'($urandom_range(1, 3));
                phase_len = 200;
            end else if (phases_run == 3) begin
                nc = 8'd255;
                phase_len = 520 + $urandom_range(0, 40);
            end else begin
                case ($urandom_range(0, 9))
                    0:       nc = 8'd0;
                    1:       nc = 8'($urandom_range(9, 40));
                    default: nc = 8'($urandom_range(1, 6));
                endcase
                phase_len = $urandom_range(15, 120);
            end
            write_reg(odd_pkg::CFG_OFFSET_X, 24'(ox));
            write_reg(odd_pkg::CFG_OFFSET_Y, 24'(oy));
            write_reg(odd_pkg::CFG_INV_SCALE, inv);
            write_reg(odd_pkg::CFG_THRESHOLD, 24'(thr));
            write_reg(odd_pkg::CFG_NUM_CLASS, 24'(nc));
            // output held off while words keep coming, so the input backs up
            if (phases_run == 1) hold_req++;

            repeat (phase_len) begin
                slot = 4 + eff_classes();
                r = $urandom_range(0, 99);
                if (pos_q >= slot) begin
                    if (r < 80) w = 32'($urandom_range(0, 411774)) - 32'sd205887;
                    else if (r < 95) w = $urandom;
                    else w = extreme_word();
                end else if (pos_q < 4) begin
                    if (r < 75) w = $urandom_range(0, 32'h0fffffff);
                    else if (r < 90) w = $urandom;
                    else w = extreme_word();
                end else begin
                    // scores: mostly in range, a share of exact ties and negatives
                    if (r < 45) w = $urandom_range(0, 65536);
                    else if (r < 65) w = 32'($urandom_range(0, 4)) <<< 14;
                    else if (r < 80) w = -32'($urandom_range(0, 65536));
                    else if (r < 92) w = $urandom;
                    else w = extreme_word();
                end
                send_word(w, 1'b0, '0);
            end
            phases_run++;
        end

        drain();
        $display("run covered %0d words over %0d register phases, %0d detections checked",
                 words_sent, phases_run, dets_checked);
        $display("%0d register writes, %0d mismatches", reg_writes, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
